FILE: rtl/hmbo_pkg.sv
// Package for the handheld memory bus with sprite-table DMA.
// Holds request codes, address region codes, store depths, request structs and the decoder.
// No dependencies; hmbo_in_if, hmbo_stores and the top level import it.
`timescale 1ns / 1ps

package hmbo_pkg;

  // Request type codes carried by an input transaction.
  typedef logic [1:0] req_type_t;
  localparam req_type_t REQ_READ  = 2'd0;
  localparam req_type_t REQ_WRITE = 2'd1;
  localparam req_type_t REQ_TICK  = 2'd2;
  localparam req_type_t REQ_IRQ   = 2'd3;

  // Address regions after decode.
  typedef logic [3:0] region_t;
  localparam region_t RG_CART  = 4'd0;
  localparam region_t RG_VRAM  = 4'd1;
  localparam region_t RG_WRAM  = 4'd2;
  localparam region_t RG_OAM   = 4'd3;
  localparam region_t RG_UNMAP = 4'd4;
  localparam region_t RG_JOY   = 4'd5;
  localparam region_t RG_DIV   = 4'd6;
  localparam region_t RG_IF    = 4'd7;
  localparam region_t RG_IO    = 4'd8;
  localparam region_t RG_HRAM  = 4'd9;
  localparam region_t RG_IE    = 4'd10;

  // Store depths.
  localparam int VRAM_DEPTH = 8192;
  localparam int WRAM_DEPTH = 8192;
  localparam int OAM_DEPTH  = 160;
  localparam int IO_DEPTH   = 128;
  localparam int HRAM_DEPTH = 127;

  // Address map boundaries.
  localparam logic [15:0] ADDR_VRAM_LO  = 16'h8000;
  localparam logic [15:0] ADDR_VRAM_HI  = 16'h9FFF;
  localparam logic [15:0] ADDR_XRAM_LO  = 16'hA000;
  localparam logic [15:0] ADDR_XRAM_HI  = 16'hBFFF;
  localparam logic [15:0] ADDR_ECHO_HI  = 16'hFDFF;
  localparam logic [15:0] ADDR_OAM_HI   = 16'hFE9F;
  localparam logic [15:0] ADDR_UNMAP_HI = 16'hFEFF;
  localparam logic [15:0] ADDR_JOY      = 16'hFF00;
  localparam logic [15:0] ADDR_DIV      = 16'hFF04;
  localparam logic [15:0] ADDR_IF       = 16'hFF0F;
  localparam logic [15:0] ADDR_IO_HI    = 16'hFF7F;
  localparam logic [15:0] ADDR_HRAM_HI  = 16'hFFFE;

  // Offset of the DMA trigger register inside the I/O page.
  localparam logic [6:0] IO_DMA_IDX = 7'h46;

  // Byte returned for unmapped reads.
  localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;

  typedef logic [12:0] st_idx_t;

  typedef struct packed {
    region_t region;
    st_idx_t idx;
  } dec_t;

  typedef struct packed {
    logic    en;
    region_t region;
    st_idx_t idx;
  } rd_req_t;

  typedef struct packed {
    logic       en;
    region_t    region;
    st_idx_t    idx;
    logic [7:0] data;
  } wr_req_t;

  // Map a bus address onto a region and an index within that region's store.
  function automatic dec_t addr_decode(input logic [15:0] a);
    dec_t d;
    d.idx = a[12:0];
    if (a < ADDR_VRAM_LO || (a >= ADDR_XRAM_LO && a <= ADDR_XRAM_HI)) begin
      d.region = RG_CART;
    end else if (a <= ADDR_VRAM_HI) begin
      d.region = RG_VRAM;
    end else if (a <= ADDR_ECHO_HI) begin
      // Work RAM and its echo window share the low 13 address bits.
      d.region = RG_WRAM;
    end else if (a <= ADDR_OAM_HI) begin
      d.region = RG_OAM;
    end else if (a <= ADDR_UNMAP_HI) begin
      d.region = RG_UNMAP;
    end else if (a == ADDR_JOY) begin
      d.region = RG_JOY;
    end else if (a == ADDR_DIV) begin
      d.region = RG_DIV;
    end else if (a == ADDR_IF) begin
      d.region = RG_IF;
    end else if (a <= ADDR_IO_HI) begin
      d.region = RG_IO;
    end else if (a <= ADDR_HRAM_HI) begin
      d.region = RG_HRAM;
    end else begin
      d.region = RG_IE;
    end
    return d;
  endfunction

endpackage

FILE: rtl/hmbo_in_if.sv
// Request channel of the memory bus: valid/ready handshake with the request fields.
// Depends on hmbo_pkg for the request type.
`timescale 1ns / 1ps

interface hmbo_in_if;
  import hmbo_pkg::*;

  logic      valid;
  logic      ready;
  req_type_t req_type;
  logic [15:0] addr;
  logic [7:0]  wdata;
  logic [2:0]  irq_bit;
  logic [7:0]  cart_rdata;
  logic [7:0]  joy_value;

  modport source (
    output valid, req_type, addr, wdata, irq_bit, cart_rdata, joy_value,
    input  ready
  );

  modport sink (
    input  valid, req_type, addr, wdata, irq_bit, cart_rdata, joy_value,
    output ready
  );
endinterface

FILE: rtl/hmbo_out_if.sv
// Result channel of the memory bus: valid/ready handshake with the result fields.
// No package dependency.
`timescale 1ns / 1ps

interface hmbo_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic       cart_write;
  logic       dma_external;

  modport source (
    output valid, rdata, cart_write, dma_external,
    input  ready
  );

  modport sink (
    input  valid, rdata, cart_write, dma_external,
    output ready
  );
endinterface

FILE: rtl/hmbo_stores.sv
// On-chip stores of the memory bus: video RAM, work RAM, sprite table, I/O page and high RAM.
// One registered read port and one write port; depends on hmbo_pkg.
`timescale 1ns / 1ps

module hmbo_stores (
  input  logic              clk,
  input  logic              rst_n,
  input  hmbo_pkg::rd_req_t rd_req,
  input  hmbo_pkg::wr_req_t wr_req,
  output logic [7:0]        rd_data
);
  import hmbo_pkg::*;

  logic [7:0] vram_mem [0:VRAM_DEPTH-1];
  logic [7:0] wram_mem [0:WRAM_DEPTH-1];
  logic [7:0] oam_mem  [0:OAM_DEPTH-1];
  logic [7:0] io_mem   [0:IO_DEPTH-1];
  logic [7:0] hram_mem [0:HRAM_DEPTH-1];

  logic [7:0] vram_q_r;
  logic [7:0] wram_q_r;
  logic [7:0] oam_q_r;
  logic [7:0] io_q_r;
  logic [7:0] hram_q_r;
  region_t    sel_r;
  logic       io_vld_q_r;

  // I/O entries read as zero until written.
  logic [IO_DEPTH-1:0] io_vld_r;
  logic [IO_DEPTH-1:0] io_vld_nxt;

  logic wr_vram, wr_wram, wr_oam, wr_io, wr_hram;
  logic rd_vram, rd_wram, rd_oam, rd_io, rd_hram;

  assign wr_vram = wr_req.en && (wr_req.region == RG_VRAM);
  assign wr_wram = wr_req.en && (wr_req.region == RG_WRAM);
  assign wr_oam  = wr_req.en && (wr_req.region == RG_OAM);
  assign wr_io   = wr_req.en && (wr_req.region == RG_IO);
  assign wr_hram = wr_req.en && (wr_req.region == RG_HRAM);

  assign rd_vram = rd_req.en && (rd_req.region == RG_VRAM);
  assign rd_wram = rd_req.en && (rd_req.region == RG_WRAM);
  assign rd_oam  = rd_req.en && (rd_req.region == RG_OAM);
  assign rd_io   = rd_req.en && (rd_req.region == RG_IO);
  assign rd_hram = rd_req.en && (rd_req.region == RG_HRAM);

  // Video RAM port.
  always_ff @(posedge clk) begin
    if (wr_vram) begin
      vram_mem[wr_req.idx] <= wr_req.data;
    end
    if (rd_vram) begin
      vram_q_r <= vram_mem[rd_req.idx];
    end
  end

  // Work RAM port, shared by the echo window.
  always_ff @(posedge clk) begin
    if (wr_wram) begin
      wram_mem[wr_req.idx] <= wr_req.data;
    end
    if (rd_wram) begin
      wram_q_r <= wram_mem[rd_req.idx];
    end
  end

  // Sprite table port.
  always_ff @(posedge clk) begin
    if (wr_oam) begin
      oam_mem[wr_req.idx[7:0]] <= wr_req.data;
    end
    if (rd_oam) begin
      oam_q_r <= oam_mem[rd_req.idx[7:0]];
    end
  end

  // I/O page port.
  always_ff @(posedge clk) begin
    if (wr_io) begin
      io_mem[wr_req.idx[6:0]] <= wr_req.data;
    end
    if (rd_io) begin
      io_q_r <= io_mem[rd_req.idx[6:0]];
    end
  end

  // High RAM port.
  always_ff @(posedge clk) begin
    if (wr_hram) begin
      hram_mem[wr_req.idx[6:0]] <= wr_req.data;
    end
    if (rd_hram) begin
      hram_q_r <= hram_mem[rd_req.idx[6:0]];
    end
  end

  // Valid bits of the I/O page.
  always_comb begin
    io_vld_nxt = io_vld_r;
    if (wr_io) begin
      io_vld_nxt[wr_req.idx[6:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      io_vld_r <= '0;
    end else begin
      io_vld_r <= io_vld_nxt;
    end
  end

  // Remember which store the last read addressed.
  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      sel_r      <= rd_req.region;
      io_vld_q_r <= io_vld_r[rd_req.idx[6:0]];
    end
  end

  // Read data select.
  always_comb begin
    unique case (sel_r)
      RG_VRAM: rd_data = vram_q_r;
      RG_WRAM: rd_data = wram_q_r;
      RG_OAM:  rd_data = oam_q_r;
      RG_IO:   rd_data = io_vld_q_r ? io_q_r : 8'h00;
      RG_HRAM: rd_data = hram_q_r;
      default: rd_data = 8'h00;
    endcase
  end

endmodule

FILE: rtl/handheld_memory_bus_oam_dma.sv
// Top level of the handheld memory bus with sprite-table DMA.
// Depends on hmbo_pkg, hmbo_in_if, hmbo_out_if and hmbo_stores.
//
//   Channel  Direction  Handshake     Carries
//   in_ch    sink       valid/ready   req_type, addr, wdata, irq_bit, cart_rdata, joy_value
//   out_ch   source     valid/ready   rdata, cart_write, dma_external
//
// Each transaction has an accept step that issues the store read and an execute state
// that forms the result and performs the write. A DMA register write with an on-chip
// source page copies min(DMA_LENGTH, 160) bytes to the sprite table, one byte a cycle
// through the single store read port. The result register holds a finished result while
// the next transaction is accepted; a second result stalls in the execute state until
// out_ch.ready. Reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps

module handheld_memory_bus_oam_dma #(
  parameter int DMA_LENGTH = 160
) (
  input  logic       clk,
  input  logic       rst_n,
  hmbo_in_if.sink    in_ch,
  hmbo_out_if.source out_ch
);
  import hmbo_pkg::*;

  // Bytes actually landing in the sprite table; the rest would be dropped.
  localparam int COPY_LEN = (DMA_LENGTH < OAM_DEPTH) ? DMA_LENGTH : OAM_DEPTH;
  localparam int CNT_W    = $clog2(COPY_LEN + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DMA  = 2'd2;

  logic [1:0] state_r, state_nxt;

  // Captured transaction.
  req_type_t   type_r;
  logic [15:0] addr_r;
  logic [7:0]  wdata_r;
  logic [2:0]  irq_bit_r;
  logic [7:0]  cart_r;
  logic [7:0]  joy_r;

  // Divider, interrupt flags and interrupt enable live in flops.
  logic [7:0] div_r, div_nxt;
  logic [7:0] if_r, if_nxt;
  logic [7:0] ie_r, ie_nxt;

  region_t          rd_region_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_rdata_r;
  logic       out_cw_r;
  logic       out_ext_r;

  logic       in_fire;
  logic       out_free;
  logic       exec_done;
  logic       dma_reg_wr;
  logic       page_cart;
  logic       dma_start;
  dec_t       dec_in, dec_req, dec_dma, dec_page;
  logic [7:0] st_rdata;
  logic [7:0] bus_byte;
  rd_req_t    rd_req;
  wr_req_t    wr_req;

  hmbo_stores u_stores (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_req  (rd_req),
    .wr_req  (wr_req),
    .rd_data (st_rdata)
  );

  // Handshake and decode.
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign exec_done   = (state_r == ST_EXEC) && out_free;

  assign dec_in   = addr_decode(in_ch.addr);
  assign dec_req  = addr_decode(addr_r);
  assign dec_dma  = addr_decode({wdata_r, 8'(cnt_r)});
  assign dec_page = addr_decode({wdata_r, 8'h00});

  assign page_cart  = (dec_page.region == RG_CART);
  assign dma_reg_wr = (type_r == REQ_WRITE) && (dec_req.region == RG_IO) &&
                      (dec_req.idx[6:0] == IO_DMA_IDX);
  assign dma_start  = dma_reg_wr && !page_cart;

  // Byte seen on the bus for the most recently issued read.
  always_comb begin
    case (rd_region_r) inside
      RG_CART:  bus_byte = cart_r;
      RG_JOY:   bus_byte = joy_r;
      RG_DIV:   bus_byte = div_r;
      RG_IF:    bus_byte = if_r;
      RG_IE:    bus_byte = ie_r;
      RG_UNMAP: bus_byte = UNMAPPED_BYTE;
      default:  bus_byte = st_rdata;
    endcase
  end

  // Store read port: the accepted address, or the next DMA source byte.
  always_comb begin
    rd_req = '0;
    if (in_fire) begin
      rd_req.en     = 1'b1;
      rd_req.region = dec_in.region;
      rd_req.idx    = dec_in.idx;
    end else if ((state_r == ST_DMA) && (cnt_r < CNT_W'(COPY_LEN))) begin
      rd_req.en     = 1'b1;
      rd_req.region = dec_dma.region;
      rd_req.idx    = dec_dma.idx;
    end
  end

  // Store write port: a bus write, or the DMA byte read in the previous cycle.
  always_comb begin
    wr_req = '0;
    if (exec_done && (type_r == REQ_WRITE)) begin
      wr_req.region = dec_req.region;
      wr_req.idx    = dec_req.idx;
      wr_req.data   = wdata_r;
      case (dec_req.region) inside
        RG_VRAM, RG_WRAM, RG_OAM, RG_HRAM: wr_req.en = 1'b1;
        RG_IO:   wr_req.en = !dma_reg_wr;
        default: wr_req.en = 1'b0;
      endcase
    end else if ((state_r == ST_DMA) && (cnt_r != '0)) begin
      wr_req.en     = 1'b1;
      wr_req.region = RG_OAM;
      wr_req.idx    = st_idx_t'(cnt_r - CNT_W'(1));
      wr_req.data   = bus_byte;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_nxt = dma_start ? ST_DMA : ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      ST_DMA: begin
        if (cnt_r == CNT_W'(COPY_LEN)) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Divider, interrupt flag and interrupt enable updates.
  always_comb begin
    div_nxt = div_r;
    if_nxt  = if_r;
    ie_nxt  = ie_r;
    if (exec_done) begin
      case (type_r)
        REQ_TICK: div_nxt = div_r + 8'd1;
        REQ_IRQ:  if_nxt  = if_r | (8'd1 << irq_bit_r);
        REQ_WRITE: begin
          if (dec_req.region == RG_DIV) begin
            div_nxt = 8'h00;
          end
          if (dec_req.region == RG_IF) begin
            if_nxt = wdata_r;
          end
          if (dec_req.region == RG_IE) begin
            ie_nxt = wdata_r;
          end
        end
        default: ;
      endcase
    end
  end

  // Result register valid.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      div_r       <= 8'h00;
      if_r        <= 8'h00;
      ie_r        <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      div_r       <= div_nxt;
      if_r        <= if_nxt;
      ie_r        <= ie_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Transaction capture and read tracking.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      type_r    <= in_ch.req_type;
      addr_r    <= in_ch.addr;
      wdata_r   <= in_ch.wdata;
      irq_bit_r <= in_ch.irq_bit;
      cart_r    <= in_ch.cart_rdata;
      joy_r     <= in_ch.joy_value;
    end
    if (rd_req.en) begin
      rd_region_r <= rd_req.region;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (exec_done) begin
      out_rdata_r <= (type_r == REQ_READ) ? bus_byte : 8'h00;
      out_cw_r    <= (type_r == REQ_WRITE) && (dec_req.region == RG_CART);
      out_ext_r   <= dma_reg_wr && page_cart;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.rdata        = out_rdata_r;
  assign out_ch.cart_write   = out_cw_r;
  assign out_ch.dma_external = out_ext_r;

endmodule
